@@ src/ljpf_pkg.sv @@
// Shared types and constants of the Lennard-Jones pair force pipeline.
`timescale 1ns / 1ps

package ljpf_pkg;

    // Field widths
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CAP_W     = 62;   // intermediates are held below 2^62
    localparam int MUL_CHUNK = 32;   // partial product slice width

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COHESION   = 2'd2;

    // Register reset values
    localparam logic [31:0] SIGMA_RST      = 32'd222822;
    localparam logic [31:0] WELL_DEPTH_RST = 32'd131072;
    localparam logic [31:0] COHESION_RST   = 32'd65536;

    // Output limits: positive maximum, and magnitude of the negative limit
    localparam logic [OUT_W-1:0] OUT_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_LIM = 48'h8000_0000_0000;

    // Pipeline control handed to the arithmetic units
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    // Displacement taken apart into magnitudes and signs
    typedef struct packed {
        logic [2:0][IN_W-1:0] mag;
        logic [2:0]           neg;
        logic                 zero;
    } geom_t;

    typedef struct packed {
        geom_t       geom;
        logic [63:0] r2;
    } pair_t;

endpackage

@@ src/lennard_jones_pair_force.sv @@
// Top level of the Lennard-Jones 12-6 pair energy and force pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                  Handshake
// input     in         s_dx, s_dy, s_dz                       s_valid / s_ready
// result    out        m_energy, m_force_x/y/z, m_zero_distance,
//                      m_saturated                            m_valid / m_ready
// config    in         cfg_index, cfg_data                    cfg_valid / cfg_ready
//
// One item enters per cycle while s_ready is high. From input accept, an item passes through
// 3 input stages, the 63-stage sigma^2/r2 divider, ten multiplier stages, 2 bracket stages,
// the 49-stage force dividers and the output register.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A two-entry output stage (output register plus skid) lets the pipeline keep taking
// items while a result waits; the whole pipeline stalls only when both are full.

module lennard_jones_pair_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ljpf_pkg::IN_W-1:0]  s_dx,
    input  logic signed [ljpf_pkg::IN_W-1:0]  s_dy,
    input  logic signed [ljpf_pkg::IN_W-1:0]  s_dz,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ljpf_pkg::OUT_W-1:0] m_energy,
    output logic signed [ljpf_pkg::OUT_W-1:0] m_force_x,
    output logic signed [ljpf_pkg::OUT_W-1:0] m_force_y,
    output logic signed [ljpf_pkg::OUT_W-1:0] m_force_z,
    output logic                              m_zero_distance,
    output logic                              m_saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ljpf_pkg::*;

    typedef struct packed {
        pair_t            pair;
        logic [CAP_W-1:0] s;
        logic             ovf;
    } m1_tag_t;

    typedef struct packed {
        pair_t pair;
        logic  ovf;
    } mid_tag_t;

    typedef struct packed {
        pair_t pair;
        logic  ovf;
        logic  bneg_e;
        logic  bneg_f;
        logic  bmf_nz;
    } m4_tag_t;

    typedef struct packed {
        pair_t            pair;
        logic             ovf;
        logic [OUT_W-1:0] energy;
        logic             e_sat;
        logic [2:0]       fneg;
    } tail_t;

    typedef struct packed {
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] fx;
        logic [OUT_W-1:0] fy;
        logic [OUT_W-1:0] fz;
        logic             zero;
        logic             sat;
    } res_t;

    // Configuration registers and derived constants
    logic [31:0] sigma_reg, well_depth_reg, cohesion_reg;
    logic [63:0] sig2_reg;
    logic [37:0] eps48_reg;
    logic [33:0] eps4;
    logic [31:0] cmag;
    logic        cneg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg      <= SIGMA_RST;
            well_depth_reg <= WELL_DEPTH_RST;
            cohesion_reg   <= COHESION_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIGMA:      sigma_reg      <= cfg_data;
                CFG_WELL_DEPTH: well_depth_reg <= cfg_data;
                CFG_COHESION:   cohesion_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sig2_reg  <= 64'(sigma_reg) * 64'(sigma_reg);
        eps48_reg <= (38'(well_depth_reg) << 5) + (38'(well_depth_reg) << 4);
    end

    assign eps4 = {well_depth_reg, 2'b00};
    assign cneg = cohesion_reg[31];
    assign cmag = cneg ? (32'd0 - cohesion_reg) : cohesion_reg;

    // Pipeline enable and output buffering
    logic en;
    logic skid_valid_reg, m_valid_reg;
    res_t skid_reg, out_reg, fin;
    logic pipe_valid;

    assign en      = ~skid_valid_reg;
    assign s_ready = en;

    // Input stage: magnitudes and signs
    logic [2:0][IN_W-1:0] in_v;
    geom_t                g_in, g1_reg, g2_reg;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [63:0]          sq2_reg [3];
    pair_t                pair3_reg;

    assign in_v = {s_dz, s_dy, s_dx};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            g_in.neg[k] = in_v[k][IN_W-1];
            g_in.mag[k] = g_in.neg[k] ? (IN_W'(0) - in_v[k]) : in_v[k];
        end
        g_in.zero = (in_v[0] == '0) && (in_v[1] == '0) && (in_v[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Squares, then r2
    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg <= g_in;
            for (int k = 0; k < 3; k++) begin
                sq2_reg[k] <= 64'(g1_reg.mag[k]) * 64'(g1_reg.mag[k]);
            end
            g2_reg         <= g1_reg;
            pair3_reg.geom <= g2_reg;
            pair3_reg.r2   <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        end
    end

    // s = sigma^2 / r2
    logic             ds_valid, ds_ovf;
    logic [CAP_W-1:0] ds_q;
    pair_t            ds_tag;

    ljpf_div #(
        .NW(64 + FRAC_BITS), .DW(64), .QW(CAP_W), .TW($bits(pair_t))
    ) u_div_s (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: v3_reg}),
        .num_i   ({sig2_reg, FRAC_BITS'(0)}),
        .den_i   (pair3_reg.r2),
        .tag_i   (pair3_reg),
        .valid_o (ds_valid),
        .q_o     (ds_q),
        .ovf_o   (ds_ovf),
        .tag_o   (ds_tag)
    );

    // s^2
    m1_tag_t                m1_in, m1_tag;
    logic                   m1_valid;
    logic [2*CAP_W-1:0]     m1_p, s2_full;
    logic                   ovf1;

    assign m1_in = '{pair: ds_tag, s: ds_q, ovf: ds_ovf};

    ljpf_mul #(.AW(CAP_W), .BW(CAP_W), .TW($bits(m1_tag_t))) u_mul_s2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: ds_valid}),
        .a_i     (ds_q),
        .b_i     (ds_q),
        .tag_i   (m1_in),
        .valid_o (m1_valid),
        .p_o     (m1_p),
        .tag_o   (m1_tag)
    );

    assign s2_full = m1_p >> FRAC_BITS;
    assign ovf1    = |s2_full[2*CAP_W-1:CAP_W];

    // r6 = s^2 * s
    mid_tag_t           m2_in, m2_tag;
    logic               m2_valid;
    logic [2*CAP_W-1:0] m2_p, r6_full;
    logic               ovf2;
    logic [CAP_W-1:0]   r6;

    assign m2_in = '{pair: m1_tag.pair, ovf: m1_tag.ovf | ovf1};

    ljpf_mul #(.AW(CAP_W), .BW(CAP_W), .TW($bits(mid_tag_t))) u_mul_r6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m1_valid}),
        .a_i     (s2_full[CAP_W-1:0]),
        .b_i     (m1_tag.s),
        .tag_i   (m2_in),
        .valid_o (m2_valid),
        .p_o     (m2_p),
        .tag_o   (m2_tag)
    );

    assign r6_full = m2_p >> FRAC_BITS;
    assign ovf2    = |r6_full[2*CAP_W-1:CAP_W];
    assign r6      = r6_full[CAP_W-1:0];

    // r12 = r6^2 and c * r6 side by side
    mid_tag_t           m3_in, m3_tag;
    logic               m3_valid;
    logic [2*CAP_W-1:0] m3a_p, r12_full;
    logic [CAP_W+31:0]  m3b_p, cr_full, hcr_full;
    logic               ovf3;
    logic [63:0]        r12, cr, hcr;

    assign m3_in = '{pair: m2_tag.pair, ovf: m2_tag.ovf | ovf2};

    ljpf_mul #(.AW(CAP_W), .BW(CAP_W), .TW($bits(mid_tag_t))) u_mul_r12 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m2_valid}),
        .a_i     (r6),
        .b_i     (r6),
        .tag_i   (m3_in),
        .valid_o (m3_valid),
        .p_o     (m3a_p),
        .tag_o   (m3_tag)
    );

    ljpf_mul #(.AW(32), .BW(CAP_W), .TW(1)) u_mul_cr6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m2_valid}),
        .a_i     (cmag),
        .b_i     (r6),
        .tag_i   (1'b0),
        .valid_o (),
        .p_o     (m3b_p),
        .tag_o   ()
    );

    assign r12_full = m3a_p >> FRAC_BITS;
    assign ovf3     = |r12_full[2*CAP_W-1:CAP_W];
    assign r12      = 64'(r12_full[CAP_W-1:0]);
    assign cr_full  = m3b_p >> FRAC_BITS;
    assign hcr_full = m3b_p >> (FRAC_BITS + 1);
    assign cr       = cr_full[63:0];
    assign hcr      = hcr_full[63:0];

    // Brackets, wrapping 64-bit signed
    logic        vb_reg, vm_reg;
    pair_t       pairb_reg, pairm_reg;
    logic        ovfb_reg, ovfm_reg;
    logic [63:0] b_reg, bf_reg, bme_reg, bmf_reg;
    logic        bnege_reg, bnegf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vm_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= m3_valid;
            vm_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pairb_reg <= m3_tag.pair;
            ovfb_reg  <= m3_tag.ovf | ovf3;
            b_reg     <= cneg ? (r12 + cr)  : (r12 - cr);
            bf_reg    <= cneg ? (r12 + hcr) : (r12 - hcr);
            // magnitudes
            pairm_reg <= pairb_reg;
            ovfm_reg  <= ovfb_reg;
            bnege_reg <= b_reg[63];
            bnegf_reg <= bf_reg[63];
            bme_reg   <= b_reg[63]  ? (64'd0 - b_reg)  : b_reg;
            bmf_reg   <= bf_reg[63] ? (64'd0 - bf_reg) : bf_reg;
        end
    end

    // Energy and force products with epsilon
    m4_tag_t     m4_in, m4_tag;
    logic        m4_valid;
    logic [97:0] m4e_p, e_full, lim_e;
    logic [101:0] m4f_p;
    logic        e_clip;
    logic [OUT_W-1:0] e_mag, e_val;

    assign m4_in = '{pair: pairm_reg, ovf: ovfm_reg, bneg_e: bnege_reg,
                     bneg_f: bnegf_reg, bmf_nz: (bmf_reg != '0)};

    ljpf_mul #(.AW(34), .BW(64), .TW($bits(m4_tag_t))) u_mul_e (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: vm_reg}),
        .a_i     (eps4),
        .b_i     (bme_reg),
        .tag_i   (m4_in),
        .valid_o (m4_valid),
        .p_o     (m4e_p),
        .tag_o   (m4_tag)
    );

    ljpf_mul #(.AW(38), .BW(64), .TW(1)) u_mul_f (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: vm_reg}),
        .a_i     (eps48_reg),
        .b_i     (bmf_reg),
        .tag_i   (1'b0),
        .valid_o (),
        .p_o     (m4f_p),
        .tag_o   ()
    );

    // Energy clip and sign
    assign e_full = m4e_p >> FRAC_BITS;
    assign lim_e  = 98'(m4_tag.bneg_e ? OUT_NEG_LIM : OUT_MAX);
    assign e_clip = e_full > lim_e;
    assign e_mag  = e_clip ? lim_e[OUT_W-1:0] : e_full[OUT_W-1:0];
    assign e_val  = m4_tag.bneg_e ? (OUT_W'(0) - e_mag) : e_mag;

    // Force numerators, one per component
    tail_t        m5_in, m5_tag;
    logic         m5_valid;
    logic [133:0] m5_p [3];
    logic [2:0]   fneg_in;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fneg_in[k] = m4_tag.bmf_nz && (m4_tag.pair.geom.mag[k] != '0)
                       && (m4_tag.bneg_f == m4_tag.pair.geom.neg[k]);
        end
    end

    assign m5_in = '{pair: m4_tag.pair, ovf: m4_tag.ovf, energy: e_val,
                     e_sat: e_clip, fneg: fneg_in};

    ljpf_mul #(.AW(102), .BW(32), .TW($bits(tail_t))) u_mul_n0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m4_valid}),
        .a_i     (m4f_p),
        .b_i     (m4_tag.pair.geom.mag[0]),
        .tag_i   (m5_in),
        .valid_o (m5_valid),
        .p_o     (m5_p[0]),
        .tag_o   (m5_tag)
    );

    ljpf_mul #(.AW(102), .BW(32), .TW(1)) u_mul_n1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m4_valid}),
        .a_i     (m4f_p),
        .b_i     (m4_tag.pair.geom.mag[1]),
        .tag_i   (1'b0),
        .valid_o (),
        .p_o     (m5_p[1]),
        .tag_o   ()
    );

    ljpf_mul #(.AW(102), .BW(32), .TW(1)) u_mul_n2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m4_valid}),
        .a_i     (m4f_p),
        .b_i     (m4_tag.pair.geom.mag[2]),
        .tag_i   (1'b0),
        .valid_o (),
        .p_o     (m5_p[2]),
        .tag_o   ()
    );

    // Force quotients by r2
    tail_t            dv_tag;
    logic [OUT_W-1:0] fq [3];
    logic [2:0]       fovf;

    ljpf_div #(.NW(134), .DW(64), .QW(OUT_W), .TW($bits(tail_t))) u_div_f0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m5_valid}),
        .num_i   (m5_p[0]),
        .den_i   (m5_tag.pair.r2),
        .tag_i   (m5_tag),
        .valid_o (pipe_valid),
        .q_o     (fq[0]),
        .ovf_o   (fovf[0]),
        .tag_o   (dv_tag)
    );

    ljpf_div #(.NW(134), .DW(64), .QW(OUT_W), .TW(1)) u_div_f1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m5_valid}),
        .num_i   (m5_p[1]),
        .den_i   (m5_tag.pair.r2),
        .tag_i   (1'b0),
        .valid_o (),
        .q_o     (fq[1]),
        .ovf_o   (fovf[1]),
        .tag_o   ()
    );

    ljpf_div #(.NW(134), .DW(64), .QW(OUT_W), .TW(1)) u_div_f2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ('{en: en, valid: m5_valid}),
        .num_i   (m5_p[2]),
        .den_i   (m5_tag.pair.r2),
        .tag_i   (1'b0),
        .valid_o (),
        .q_o     (fq[2]),
        .ovf_o   (fovf[2]),
        .tag_o   ()
    );

    // Result assembly: zero distance, intermediate overflow, normal path
    logic [OUT_W-1:0] f_lim [3];
    logic [OUT_W-1:0] f_mag [3];
    logic [OUT_W-1:0] f_val [3];
    logic [2:0]       f_clip;
    logic             eps_nz;

    assign eps_nz = (well_depth_reg != '0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            f_lim[k]  = dv_tag.fneg[k] ? OUT_NEG_LIM : OUT_MAX;
            f_clip[k] = fovf[k] || (fq[k] > f_lim[k]);
            f_mag[k]  = f_clip[k] ? f_lim[k] : fq[k];
            f_val[k]  = (dv_tag.fneg[k] && (f_mag[k] != '0)) ?
                        (OUT_W'(0) - f_mag[k]) : f_mag[k];
        end
        priority if (dv_tag.pair.geom.zero) begin
            fin = '{energy: '0, fx: '0, fy: '0, fz: '0, zero: 1'b1, sat: 1'b0};
        end else if (dv_tag.ovf) begin
            fin.zero   = 1'b0;
            fin.sat    = eps_nz;
            fin.energy = eps_nz ? OUT_MAX : '0;
            for (int k = 0; k < 3; k++) begin
                f_val[k] = (eps_nz && (dv_tag.pair.geom.mag[k] != '0)) ?
                           (dv_tag.pair.geom.neg[k] ? OUT_MAX : OUT_NEG_LIM) : '0;
            end
            fin.fx = f_val[0];
            fin.fy = f_val[1];
            fin.fz = f_val[2];
        end else begin
            fin.zero   = 1'b0;
            fin.sat    = dv_tag.e_sat | (|f_clip);
            fin.energy = dv_tag.energy;
            fin.fx     = f_val[0];
            fin.fy     = f_val[1];
            fin.fz     = f_val[2];
        end
    end

    // Output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg | pipe_valid;
            skid_valid_reg <= 1'b0;
        end else if (pipe_valid && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end else if (pipe_valid && en) begin
            skid_reg <= fin;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_energy        = out_reg.energy;
    assign m_force_x       = out_reg.fx;
    assign m_force_y       = out_reg.fy;
    assign m_force_z       = out_reg.fz;
    assign m_zero_distance = out_reg.zero;
    assign m_saturated     = out_reg.sat;

endmodule

@@ src/ljpf_mul.sv @@
// Two-stage multiplier built from 32x32 partial products, with a side tag.
`timescale 1ns / 1ps

module ljpf_mul #(
    parameter int AW = 64,
    parameter int BW = 64,
    parameter int TW = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ljpf_pkg::pipe_ctl_t ctl_i,
    input  logic [AW-1:0]      a_i,
    input  logic [BW-1:0]      b_i,
    input  logic [TW-1:0]      tag_i,
    output logic               valid_o,
    output logic [AW+BW-1:0]   p_o,
    output logic [TW-1:0]      tag_o
);
    import ljpf_pkg::*;

    localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = (NA + NB) * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0]  a_ext;
    logic [NB*MUL_CHUNK-1:0]  b_ext;
    logic [2*MUL_CHUNK-1:0]   pp_reg [NA*NB];
    logic [TW-1:0]            tag1_reg;
    logic [TW-1:0]            tag2_reg;
    logic [AW+BW-1:0]         p_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic [PW-1:0]            acc;

    assign a_ext = (NA*MUL_CHUNK)'(a_i);
    assign b_ext = (NB*MUL_CHUNK)'(b_i);

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (ctl_i.en) begin
            v1_reg <= ctl_i.valid;
            v2_reg <= v1_reg;
        end
    end

    // Sum of shifted partial products
    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PW'(pp_reg[i*NB+j]) << (MUL_CHUNK*(i+j)));
            end
        end
    end

    // Stage 1 partial products, stage 2 sum
    always_ff @(posedge aclk) begin
        if (ctl_i.en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i*NB+j] <= (2*MUL_CHUNK)'(a_ext[i*MUL_CHUNK +: MUL_CHUNK])
                                    * (2*MUL_CHUNK)'(b_ext[j*MUL_CHUNK +: MUL_CHUNK]);
                end
            end
            tag1_reg <= tag_i;
            p_reg    <= acc[AW+BW-1:0];
            tag2_reg <= tag1_reg;
        end
    end

    assign valid_o = v2_reg;
    assign p_o     = p_reg;
    assign tag_o   = tag2_reg;

endmodule

@@ src/ljpf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module ljpf_div #(
    parameter int NW = 80,
    parameter int DW = 64,
    parameter int QW = 62,
    parameter int TW = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ljpf_pkg::pipe_ctl_t ctl_i,
    input  logic [NW-1:0]      num_i,
    input  logic [DW-1:0]      den_i,
    input  logic [TW-1:0]      tag_i,
    output logic               valid_o,
    output logic [QW-1:0]      q_o,
    output logic               ovf_o,
    output logic [TW-1:0]      tag_o
);
    import ljpf_pkg::*;

    localparam int TOPW = NW - QW;
    localparam int CW   = (TOPW > DW) ? TOPW : DW;

    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic          ovf_reg  [QW+1];
    logic [TW-1:0] tag_reg  [QW+1];
    logic          v_reg    [QW+1];

    logic [CW-1:0] top_ext;
    logic          ovf0;
    logic [DW:0]   trial    [QW];
    logic          ge       [QW];
    logic [DW:0]   diff     [QW];
    logic [DW-1:0] rem_next [QW];

    // Quotient would not fit in QW bits
    assign top_ext = CW'(num_i >> QW);
    assign ovf0    = top_ext >= CW'(den_i);

    // One compare and subtract per stage
    always_comb begin
        for (int i = 0; i < QW; i++) begin
            trial[i]    = {rem_reg[i], low_reg[i][QW-1]};
            ge[i]       = trial[i] >= {1'b0, den_reg[i]};
            diff[i]     = trial[i] - {1'b0, den_reg[i]};
            rem_next[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QW; i++) v_reg[i] <= 1'b0;
        end else if (ctl_i.en) begin
            v_reg[0] <= ctl_i.valid;
            for (int i = 0; i < QW; i++) v_reg[i+1] <= v_reg[i];
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (ctl_i.en) begin
            rem_reg[0] <= top_ext[DW-1:0];
            low_reg[0] <= num_i[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den_i;
            ovf_reg[0] <= ovf0;
            tag_reg[0] <= tag_i;
            for (int i = 0; i < QW; i++) begin
                rem_reg[i+1] <= rem_next[i];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], ge[i]};
                den_reg[i+1] <= den_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
            for (int i = 0; i < QW-1; i++) begin
                low_reg[i+1] <= low_reg[i] << 1;
            end
        end
    end

    assign valid_o = v_reg[QW];
    assign q_o     = q_reg[QW];
    assign ovf_o   = ovf_reg[QW];
    assign tag_o   = tag_reg[QW];

endmodule
